@@ hdl/bilateral_image_filter_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bilateral image filter checker
// ----------------------------------------------------------------------------
`ifndef BILATERAL_IMAGE_FILTER_DEFINES_SVH
`define BILATERAL_IMAGE_FILTER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define BIF_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition in one cycle brings a consequence in the next.
`define BIF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bif_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bif_pkg
// Shared constants and Gaussian weight tables of the bilateral image filter.
// ----------------------------------------------------------------------------
package bif_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int ROW_BITS = 11;
    localparam int CFG_BITS = 11;
    localparam int PIX_BITS = 8;
    localparam int WT_BITS  = 16;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // exp(-(dx^2+dy^2)/2) in Q0.16
    function automatic logic [WT_BITS-1:0] spatial_weight(input logic [2:0] ady,
                                                           input logic [2:0] adx);
        logic [6:0] s;
        logic [WT_BITS-1:0] w;
        s = 7'(ady) * 7'(ady) + 7'(adx) * 7'(adx);
        unique case (s)
            7'd0:    w = 16'd65535;
            7'd1:    w = 16'd39750;
            7'd2:    w = 16'd24109;
            7'd4:    w = 16'd8869;
            7'd5:    w = 16'd5379;
            7'd8:    w = 16'd1200;
            7'd9:    w = 16'd728;
            7'd10:   w = 16'd442;
            7'd13:   w = 16'd99;
            7'd16:   w = 16'd22;
            7'd17:   w = 16'd13;
            7'd18:   w = 16'd8;
            7'd20:   w = 16'd3;
            default: w = '0;
        endcase
        return w;
    endfunction

    // exp(-d^2/4) in Q0.16
    function automatic logic [WT_BITS-1:0] range_weight(input logic [PIX_BITS-1:0] d);
        logic [WT_BITS-1:0] w;
        unique case (d)
            8'd0:    w = 16'd65535;
            8'd1:    w = 16'd51039;
            8'd2:    w = 16'd24109;
            8'd3:    w = 16'd6907;
            8'd4:    w = 16'd1200;
            8'd5:    w = 16'd127;
            8'd6:    w = 16'd8;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

@@ hdl/bilateral_image_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilateral_image_filter
// Streaming grey-scale bilateral filter with line store and Gaussian weights.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): command 0 carries a raster pixel on
//   pixel_in, command 1 is a drain request sent after the frame's last pixel.
//   Output channel (out_valid/out_stall): one filtered pixel per producing
//   request, end_of_frame high on the last pixel of the frame.
//   Configuration channel (cfg_valid/cfg_ready): index 0 frame_width,
//   index 1 frame_height; a write restarts the frame. Write only while idle.
// Timing:
//   A request that produces no pixel is taken without a stall, so the first
//   RADIUS rows fill at one pixel a cycle. A producing request holds in_stall
//   while the one shared multiply-accumulate walks every window tap, one per
//   cycle through the single line-store read port, and then while a serial
//   divider forms the quotient.
// Reset clears the counters and sets 640 x 480; the line store is not cleared.
// A stalled result holds in its register while the next request is taken;
// a new result waits for that register before it is loaded.
// ----------------------------------------------------------------------------
module bilateral_image_filter
    import bif_pkg::*;
#(
    parameter int RADIUS   = 5,
    parameter int MAX_LINE = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                command,
    input  logic [PIX_BITS-1:0] pixel_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [PIX_BITS-1:0] pixel_out,
    output logic                end_of_frame,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data
);

    localparam int WIN   = 2 * RADIUS + 1;
    localparam int DEPTH = WIN * MAX_LINE;
    localparam int AW    = $clog2(DEPTH);
    localparam int WB    = $clog2(MAX_LINE + 1);
    localparam int IB    = $clog2(MAX_LINE * MAX_ROWS + 1);
    localparam int SWB   = 32 + $clog2(WIN * WIN);
    localparam int SVB   = 40 + $clog2(WIN * WIN);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WIN  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [CFG_BITS-1:0] width_reg, height_reg;
    logic [ROW_BITS-1:0] row_reg;
    logic [WB-1:0]       col_reg;
    logic [IB-1:0]       in_idx_reg;
    logic [AW-1:0]       wr_addr_reg;
    logic [AW-1:0]       out_addr_reg;
    logic [ROW_BITS-1:0] pr_reg;
    logic [WB-1:0]       pc_reg;
    logic                out_valid_reg;
    logic [PIX_BITS-1:0] pixel_out_reg;
    logic                eof_reg;

    logic [PIX_BITS-1:0] line_mem [DEPTH];
    logic [PIX_BITS-1:0] rdata_reg;
    logic [AW-1:0]       raddr;

    logic [WB-1:0]       w_eff;
    logic [ROW_BITS-1:0] h_eff;
    logic [IB-1:0]       lag;
    logic [AW-1:0]       rw;
    logic                accept, cfg_write, frame_full, take_pixel, emit_go;
    logic                out_free, load_out, is_last;
    logic                win_done, div_done;
    logic [PIX_BITS-1:0] centre, quot;
    logic [SWB-1:0]      sum_w;
    logic [SVB-1:0]      sum_wv;

    // Clamp the frame size to what the line store and row counter can hold.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WB'(1);
        else if (32'(width_reg) > MAX_LINE)
            w_eff = WB'(MAX_LINE);
        else
            w_eff = WB'(width_reg);
        if (height_reg == '0)
            h_eff = ROW_BITS'(1);
        else if (32'(height_reg) > MAX_ROWS)
            h_eff = ROW_BITS'(MAX_ROWS);
        else
            h_eff = ROW_BITS'(height_reg);
        rw  = AW'(w_eff * RADIUS);
        lag = IB'(w_eff * RADIUS) + IB'(RADIUS);
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign cfg_ready  = (state_reg == S_IDLE);
    assign cfg_write  = cfg_valid && cfg_ready
                     && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
    assign accept     = in_valid && !in_stall;
    assign frame_full = (row_reg >= h_eff);
    assign take_pixel = accept && (command == CMD_PIXEL) && !frame_full;
    // A pixel produces once the window below its centre is stored; after the
    // frame's last pixel every request drains one pending output.
    assign emit_go    = accept && ((take_pixel && in_idx_reg >= lag) || frame_full);
    assign out_free   = !out_valid_reg || !out_stall;
    assign load_out   = (state_reg == S_OUT) && out_free;
    assign is_last    = (pr_reg == h_eff - 1'b1) && (pc_reg == w_eff - 1'b1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (emit_go) state_next = S_WIN;
            S_WIN:   if (win_done) state_next = S_DIV;
            S_DIV:   if (div_done) state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= CFG_BITS'(640);
            height_reg    <= CFG_BITS'(480);
            row_reg       <= '0;
            col_reg       <= '0;
            in_idx_reg    <= '0;
            wr_addr_reg   <= '0;
            out_addr_reg  <= '0;
            pr_reg        <= '0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (load_out)
                out_valid_reg <= 1'b1;

            if (cfg_write || (load_out && is_last))
            begin
                // restart the frame
                row_reg      <= '0;
                col_reg      <= '0;
                in_idx_reg   <= '0;
                wr_addr_reg  <= '0;
                out_addr_reg <= '0;
                pr_reg       <= '0;
                pc_reg       <= '0;
                if (cfg_write && cfg_index == REG_FRAME_WIDTH)
                    width_reg <= cfg_data;
                if (cfg_write && cfg_index == REG_FRAME_HEIGHT)
                    height_reg <= cfg_data;
            end
            else
            begin
                if (take_pixel)
                begin
                    in_idx_reg  <= in_idx_reg + 1'b1;
                    wr_addr_reg <= (wr_addr_reg == AW'(DEPTH - 1)) ? '0 : wr_addr_reg + 1'b1;
                    if (col_reg == w_eff - 1'b1)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + 1'b1;
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                if (load_out)
                begin
                    out_addr_reg <= (out_addr_reg == AW'(DEPTH - 1)) ? '0 : out_addr_reg + 1'b1;
                    if (pc_reg == w_eff - 1'b1)
                    begin
                        pc_reg <= '0;
                        pr_reg <= pr_reg + 1'b1;
                    end
                    else
                    begin
                        pc_reg <= pc_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            pixel_out_reg <= quot;
            eof_reg       <= is_last;
        end
    end

    // Line store: one write port for arriving pixels, one registered read port.
    always_ff @(posedge clk)
    begin
        if (take_pixel && !cfg_write)
            line_mem[wr_addr_reg] <= pixel_in;
        rdata_reg <= line_mem[raddr];
    end

    bif_win #(
        .RADIUS   (RADIUS),
        .MAX_LINE (MAX_LINE)
    ) u_win (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (emit_go),
        .ca     (out_addr_reg),
        .pr     (pr_reg),
        .pc     (pc_reg),
        .w      (w_eff),
        .h      (h_eff),
        .rw     (rw),
        .rdata  (rdata_reg),
        .raddr  (raddr),
        .done   (win_done),
        .centre (centre),
        .sum_w  (sum_w),
        .sum_wv (sum_wv)
    );

    bif_div #(
        .DEN_BITS (SWB)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  ((state_reg == S_WIN) && win_done),
        .num    (sum_wv),
        .den    (sum_w),
        .centre (centre),
        .done   (div_done),
        .quot   (quot)
    );

    assign out_valid    = out_valid_reg;
    assign pixel_out    = pixel_out_reg;
    assign end_of_frame = eof_reg;

endmodule

@@ hdl/bif_win.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bif_win
// Window walker: reads the centre, then walks every tap through one shared
// weight multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module bif_win
    import bif_pkg::*;
#(
    parameter int RADIUS   = 5,
    parameter int MAX_LINE = 1024
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [$clog2((2*RADIUS+1)*MAX_LINE)-1:0] ca,
    input  logic [ROW_BITS-1:0]          pr,
    input  logic [$clog2(MAX_LINE+1)-1:0] pc,
    input  logic [$clog2(MAX_LINE+1)-1:0] w,
    input  logic [ROW_BITS-1:0]          h,
    input  logic [$clog2((2*RADIUS+1)*MAX_LINE)-1:0] rw,
    input  logic [PIX_BITS-1:0]          rdata,
    output logic [$clog2((2*RADIUS+1)*MAX_LINE)-1:0] raddr,
    output logic                         done,
    output logic [PIX_BITS-1:0]          centre,
    output logic [32+$clog2((2*RADIUS+1)*(2*RADIUS+1))-1:0] sum_w,
    output logic [40+$clog2((2*RADIUS+1)*(2*RADIUS+1))-1:0] sum_wv
);

    localparam int WIN   = 2 * RADIUS + 1;
    localparam int DEPTH = WIN * MAX_LINE;
    localparam int AW    = $clog2(DEPTH);
    localparam int WB    = $clog2(MAX_LINE + 1);
    localparam int IXB   = $clog2(WIN);
    localparam int SWB   = 32 + $clog2(WIN * WIN);
    localparam int SVB   = 40 + $clog2(WIN * WIN);

    localparam logic [2:0] W_IDLE  = 3'd0;
    localparam logic [2:0] W_CTR   = 3'd1;
    localparam logic [2:0] W_CWAIT = 3'd2;
    localparam logic [2:0] W_WALK  = 3'd3;
    localparam logic [2:0] W_FLUSH = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [IXB-1:0]      dy_reg, dx_reg;
    logic [AW-1:0]       row_base_reg;
    logic [1:0]          flush_reg;
    logic                done_reg;
    logic [PIX_BITS-1:0] centre_reg;

    logic                p1_valid_reg;
    logic [WT_BITS-1:0]  p1_sw_reg;
    logic                p2_valid_reg;
    logic [31:0]         p2_wt_reg;
    logic [PIX_BITS-1:0] p2_v_reg;
    logic                p3_valid_reg;
    logic [39:0]         p3_wv_reg;
    logic [SWB-1:0]      sum_w_reg;
    logic [SVB-1:0]      sum_wv_reg;

    logic [AW+1:0]       tap_sum;
    logic [AW-1:0]       tap_addr;
    logic [AW:0]         init_sum, step_sum;
    logic [AW-1:0]       init_base, step_base;
    logic [ROW_BITS-1:0] y_sum;
    logic [WB:0]         x_sum;
    logic                tap_ok;
    logic [2:0]          ady, adx;
    logic                last_tap;
    logic [PIX_BITS-1:0] diff;

    always_comb
    begin
        tap_sum = (AW+2)'(row_base_reg) + (AW+2)'(DEPTH) + (AW+2)'(dx_reg) - (AW+2)'(RADIUS);
        if (tap_sum >= (AW+2)'(2 * DEPTH))
            tap_addr = AW'(tap_sum - (AW+2)'(2 * DEPTH));
        else if (tap_sum >= (AW+2)'(DEPTH))
            tap_addr = AW'(tap_sum - (AW+2)'(DEPTH));
        else
            tap_addr = AW'(tap_sum);

        init_sum  = (AW+1)'(ca) + (AW+1)'(DEPTH) - (AW+1)'(rw);
        init_base = (init_sum >= (AW+1)'(DEPTH)) ? AW'(init_sum - (AW+1)'(DEPTH))
                                                 : AW'(init_sum);
        step_sum  = (AW+1)'(row_base_reg) + (AW+1)'(w);
        step_base = (step_sum >= (AW+1)'(DEPTH)) ? AW'(step_sum - (AW+1)'(DEPTH))
                                                 : AW'(step_sum);

        y_sum  = pr + ROW_BITS'(dy_reg);
        x_sum  = (WB+1)'(pc) + (WB+1)'(dx_reg);
        tap_ok = (y_sum >= ROW_BITS'(RADIUS)) && (y_sum < h + ROW_BITS'(RADIUS))
              && (x_sum >= (WB+1)'(RADIUS)) && (x_sum < (WB+1)'(w) + (WB+1)'(RADIUS));

        ady = (dy_reg >= IXB'(RADIUS)) ? 3'(dy_reg - IXB'(RADIUS)) : 3'(IXB'(RADIUS) - dy_reg);
        adx = (dx_reg >= IXB'(RADIUS)) ? 3'(dx_reg - IXB'(RADIUS)) : 3'(IXB'(RADIUS) - dx_reg);

        last_tap = (dy_reg == IXB'(WIN - 1)) && (dx_reg == IXB'(WIN - 1));
        diff     = (rdata > centre_reg) ? rdata - centre_reg : centre_reg - rdata;
        raddr    = (state_reg == W_WALK) ? tap_addr : ca;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            W_IDLE:  if (start) state_next = W_CTR;
            W_CTR:   state_next = W_CWAIT;
            W_CWAIT: state_next = W_WALK;
            W_WALK:  if (last_tap) state_next = W_FLUSH;
            W_FLUSH: if (flush_reg == 2'd2) state_next = W_IDLE;
            default: state_next = W_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= W_IDLE;
            dy_reg       <= '0;
            dx_reg       <= '0;
            flush_reg    <= '0;
            done_reg     <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= (state_reg == W_FLUSH) && (flush_reg == 2'd2);
            p1_valid_reg <= (state_reg == W_WALK) && tap_ok;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            if (state_reg == W_IDLE)
            begin
                dy_reg    <= '0;
                dx_reg    <= '0;
                flush_reg <= '0;
            end
            else if (state_reg == W_WALK)
            begin
                if (dx_reg == IXB'(WIN - 1))
                begin
                    dx_reg <= '0;
                    dy_reg <= dy_reg + 1'b1;
                end
                else
                begin
                    dx_reg <= dx_reg + 1'b1;
                end
            end
            else if (state_reg == W_FLUSH)
            begin
                flush_reg <= flush_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == W_IDLE && start)
        begin
            row_base_reg <= init_base;
            sum_w_reg    <= '0;
            sum_wv_reg   <= '0;
        end
        else
        begin
            if (state_reg == W_WALK && dx_reg == IXB'(WIN - 1))
                row_base_reg <= step_base;
            if (p2_valid_reg)
                sum_w_reg <= sum_w_reg + SWB'(p2_wt_reg);
            if (p3_valid_reg)
                sum_wv_reg <= sum_wv_reg + SVB'(p3_wv_reg);
        end
        if (state_reg == W_CWAIT)
            centre_reg <= rdata;
        p1_sw_reg <= spatial_weight(ady, adx);
        p2_wt_reg <= 32'(p1_sw_reg) * 32'(range_weight(diff));
        p2_v_reg  <= rdata;
        p3_wv_reg <= 40'(p2_wt_reg) * 40'(p2_v_reg);
    end

    assign done   = done_reg;
    assign centre = centre_reg;
    assign sum_w  = sum_w_reg;
    assign sum_wv = sum_wv_reg;

endmodule

@@ hdl/bif_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bif_div
// Serial restoring divider, one quotient bit a cycle, eight-bit quotient.
// ----------------------------------------------------------------------------
module bif_div
    import bif_pkg::*;
#(
    parameter int DEN_BITS = 39
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DEN_BITS+7:0]      num,
    input  logic [DEN_BITS-1:0]      den,
    input  logic [PIX_BITS-1:0]      centre,
    output logic                     done,
    output logic [PIX_BITS-1:0]      quot
);

    localparam int NB = DEN_BITS + 8;

    logic                busy_reg;
    logic [2:0]          step_reg;
    logic [NB-1:0]       rem_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic [PIX_BITS-1:0] quot_reg;
    logic                done_reg;
    logic [NB-1:0]       trial;

    assign trial = NB'(den_reg) << step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= 3'd7;
                // zero total: answer with the centre pixel at once
                busy_reg <= (den != '0);
                done_reg <= (den == '0);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == 3'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= (den == '0) ? centre : '0;
        end
        else if (busy_reg && rem_reg >= trial)
        begin
            rem_reg            <= rem_reg - trial;
            quot_reg[step_reg] <= 1'b1;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ hdl/bif_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bif_checker
// Port-level checks of the bilateral image filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "bilateral_image_filter_defines.svh"

module bif_checker
    import bif_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [PIX_BITS-1:0] pixel_out,
    input  logic                end_of_frame,
    input  logic                cfg_ready
);

    `BIF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")
    `BIF_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
        $stable(pixel_out) && $stable(end_of_frame), "stalled result changed")
    `BIF_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall, !$rose(out_valid),
        "result appeared one cycle after a request")
    `BIF_ASSERT(a_result_after_busy, !$rose(out_valid) || $past(in_stall),
        "result loaded while the input side was idle")
    `BIF_ASSERT(a_cfg_only_idle, !cfg_ready || !in_stall, "configuration open while busy")

endmodule

bind bilateral_image_filter bif_checker u_bif_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_out    (pixel_out),
    .end_of_frame (end_of_frame),
    .cfg_ready    (cfg_ready)
);

@@ sim/tb_bilateral_image_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bilateral_image_filter
// Self-checking bench for the streaming bilateral image filter.
// ----------------------------------------------------------------------------
// A short table of hand-written requests covers reset, the one-pixel frame,
// drain and late-pixel cases and frame restart on a register write. A frame
// at the clamped width follows, cut short after its first drained pixels,
// then many small random frames. Each accepted request runs through a local
// model of the filter, and the filtered pixels are checked in order against
// the output channel. Both sides insert random gaps, with some stretches
// kept gap-free.
// ----------------------------------------------------------------------------
module tb_bilateral_image_filter;
    import bif_pkg::*;

    localparam int RAD        = 5;
    localparam int LINE_MAX   = 1024;
    localparam int STORE_SIZE = (2 * RAD + 1) * LINE_MAX;
    localparam int SETTLE     = 300;   // longer than one producing request

    typedef struct {
        logic [PIX_BITS-1:0] pix;
        logic                eof;
    } filtered_t;

    typedef enum {ROW_CFG, ROW_NONE, ROW_GIVEN, ROW_PREDICT} row_kind_t;

    typedef struct {
        row_kind_t kind;
        int        cmd;     // command, or register index for ROW_CFG
        int        val;     // pixel, or register data for ROW_CFG
        int        exp_pix;
        int        exp_eof;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                command;
    logic [PIX_BITS-1:0] pixel_in;
    logic                out_valid;
    logic                out_stall;
    logic [PIX_BITS-1:0] pixel_out;
    logic                end_of_frame;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [1:0]          cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    bilateral_image_filter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .pixel_in     (pixel_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_out    (pixel_out),
        .end_of_frame (end_of_frame),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // Local filter model: registers, raster counters and the line store
    // ------------------------------------------------------------------
    int unsigned gauss_by_dist_sq [21] = '{65535, 39750, 24109, 0, 8869, 5379, 0, 0,
                                           1200, 728, 442, 0, 0, 99, 0, 0, 22, 13, 8,
                                           0, 3};
    int unsigned gauss_by_diff [7] = '{65535, 51039, 24109, 6907, 1200, 127, 8};

    logic [CFG_BITS-1:0] model_width;
    logic [CFG_BITS-1:0] model_height;
    logic [7:0]          pixel_store [STORE_SIZE];
    int unsigned         in_row;
    int unsigned         in_col;
    int unsigned         out_pos;

    filtered_t pending_pixels [$];
    int        errors;
    bit        quiet;          // gap-free stretch on both sides

    function automatic int unsigned active_width();
        int unsigned w;
        w = model_width;
        if (w < 1) w = 1;
        if (w > LINE_MAX) w = LINE_MAX;
        return w;
    endfunction

    function automatic int unsigned active_height();
        int unsigned h;
        h = model_height;
        if (h < 1) h = 1;
        if (h > MAX_ROWS) h = MAX_ROWS;
        return h;
    endfunction

    function automatic void restart_frame();
        in_row  = 0;
        in_col  = 0;
        out_pos = 0;
    endfunction

    // Weighted mean of the window round the next output position.
    function automatic filtered_t filter_next_pixel(int unsigned w, int unsigned h);
        filtered_t   res;
        int          pr;
        int          pc;
        int          y;
        int          x;
        int unsigned sq;
        int unsigned diff;
        logic [7:0]  centre;
        logic [7:0]  v;
        longint unsigned wt;
        longint unsigned sum_w;
        longint unsigned sum_wv;
        pr     = out_pos / w;
        pc     = out_pos % w;
        centre = pixel_store[(pr * w + pc) % STORE_SIZE];
        sum_w  = 0;
        sum_wv = 0;
        for (int dy = -RAD; dy <= RAD; dy++) begin
            y = pr + dy;
            if (y < 0 || y >= int'(h)) continue;
            for (int dx = -RAD; dx <= RAD; dx++) begin
                x = pc + dx;
                if (x < 0 || x >= int'(w)) continue;
                v    = pixel_store[(y * w + x) % STORE_SIZE];
                sq   = dy * dy + dx * dx;
                diff = (v > centre) ? v - centre : centre - v;
                wt   = longint'(sq <= 20 ? gauss_by_dist_sq[sq] : 0)
                     * longint'(diff <= 6 ? gauss_by_diff[diff] : 0);
                sum_w  += wt;
                sum_wv += wt * v;
            end
        end
        res.pix = (sum_w != 0) ? 8'(sum_wv / sum_w) : centre;
        res.eof = (out_pos == w * h - 1);
        out_pos++;
        if (out_pos >= w * h) restart_frame();
        return res;
    endfunction

    // Advance the model by one accepted request; made is set on a result.
    function automatic void filter_request(input logic cmd, input logic [7:0] pix,
                                           output bit made, output filtered_t res);
        int unsigned w;
        int unsigned h;
        int unsigned idx;
        w    = active_width();
        h    = active_height();
        made = 0;
        res  = '{pix: '0, eof: 1'b0};
        if (cmd == CMD_PIXEL && in_row < h) begin
            idx = in_row * w + in_col;
            pixel_store[idx % STORE_SIZE] = pix;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            if (idx >= RAD * w + RAD) begin
                res  = filter_next_pixel(w, h);
                made = 1;
            end
        end
        else if (in_row >= h && out_pos < w * h) begin
            res  = filter_next_pixel(w, h);
            made = 1;
        end
    endfunction

    function automatic bit drain_pending();
        return in_row >= active_height() && out_pos < active_width() * active_height();
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and run limit
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    function automatic int draw_gap();
        return quiet ? 0 : $urandom_range(0, 19);
    endfunction

    // Send one request, then feed it to the model once it is taken.
    // Push the model's result unless the caller overrides it.
    task automatic send_request(input logic cmd, input logic [7:0] pix,
                                input row_kind_t kind, input filtered_t given);
        int        gap;
        bit        made;
        filtered_t res;
        gap = draw_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        pixel_in <= pix;
        do @(posedge clk); while (in_stall);
        filter_request(cmd, pix, made, res);
        if (kind == ROW_GIVEN) pending_pixels.push_back(given);
        else if (kind == ROW_PREDICT && made) pending_pixels.push_back(res);
    endtask

    task automatic send_pixel(input logic cmd, input logic [7:0] pix);
        send_request(cmd, pix, ROW_PREDICT, '{pix: '0, eof: 1'b0});
    endtask

    // Drop valid, let the block finish, then write one register.
    task automatic write_register(input logic [1:0] idx, input logic [CFG_BITS-1:0] data);
        in_valid <= 1'b0;
        wait (pending_pixels.size() == 0);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_FRAME_WIDTH) model_width = data;
        else model_height = data;
        restart_frame();
    endtask

    task automatic set_frame(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
        write_register(REG_FRAME_WIDTH, w);
        write_register(REG_FRAME_HEIGHT, h);
    endtask

    // Send a frame (or its first len pixels), then drain what is left if drain is set.
    // Smooth content keeps most range weights nonzero.
    task automatic run_frame(input int len, input bit smooth, input bit drain);
        int         base;
        logic [7:0] pix;
        base = $urandom_range(0, 255);
        for (int i = 0; i < len; i++) begin
            if (smooth) begin
                base = base + $urandom_range(0, 6) - 3;
                if (base < 0) base = 0;
                if (base > 255) base = 255;
                pix = 8'(base);
            end
            else pix = 8'($urandom);
            send_pixel(CMD_PIXEL, pix);
        end
        if (drain) begin
            // a pixel sent after the frame acts as a drain request
            while (drain_pending())
                send_pixel($urandom_range(0, 7) == 0 ? CMD_PIXEL : CMD_DRAIN, 8'($urandom));
        end
    endtask

    // Hand-written opening requests; the expected pixel is typed in only where
    // it is obvious (one-pixel frames and neighbors too far apart to mix).
    stim_row_t opening [26] = '{
        '{ROW_NONE,    0,   0,    0, 0},   // first pixel at 640x480: no output
        '{ROW_NONE,    1,   0,    0, 0},   // drain before the frame is in
        '{ROW_CFG,     0,   1,    0, 0},
        '{ROW_CFG,     1,   1,    0, 0},
        '{ROW_NONE,    0,   0,    0, 0},   // 1x1 frame: the pixel is only stored
        '{ROW_GIVEN,   0, 255,    0, 1},   // late pixel drains the stored pixel
        '{ROW_NONE,    1,   0,    0, 0},   // drain with nothing pending
        '{ROW_CFG,     0,   2,    0, 0},
        '{ROW_NONE,    0,   0,    0, 0},
        '{ROW_NONE,    0, 255,    0, 0},
        '{ROW_GIVEN,   1,   0,    0, 0},
        '{ROW_GIVEN,   1,   0,  255, 1},
        '{ROW_NONE,    0,  10,    0, 0},
        '{ROW_NONE,    0, 200,    0, 0},
        '{ROW_GIVEN,   0,  77,   10, 0},   // late pixel acts as a drain
        '{ROW_GIVEN,   1,   0,  200, 1},
        '{ROW_CFG,     1,   2,    0, 0},
        '{ROW_PREDICT, 0, 100,    0, 0},
        '{ROW_PREDICT, 0, 101,    0, 0},
        '{ROW_PREDICT, 0, 103,    0, 0},
        '{ROW_PREDICT, 1,   0,    0, 0},   // drain before the frame is in
        '{ROW_PREDICT, 0,  98,    0, 0},
        '{ROW_PREDICT, 1,   0,    0, 0},
        '{ROW_PREDICT, 1,   0,    0, 0},
        '{ROW_PREDICT, 1,   0,    0, 0},
        '{ROW_PREDICT, 1,   0,    0, 0}
    };

    initial begin
        int        sent;
        int        w;
        int        h;
        int        len;
        filtered_t given;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        command   = 1'b0;
        pixel_in  = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data  = '0;
        errors    = 0;
        quiet     = 1'b0;
        model_width  = 640;
        model_height = 480;
        restart_frame();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i]) begin
            if (opening[i].kind == ROW_CFG)
                write_register(opening[i].cmd == 0 ? REG_FRAME_WIDTH : REG_FRAME_HEIGHT,
                               CFG_BITS'(opening[i].val));
            else begin
                given.pix = 8'(opening[i].exp_pix);
                given.eof = opening[i].exp_eof[0];
                send_request(opening[i].cmd[0], 8'(opening[i].val), opening[i].kind, given);
            end
        end

        // Register extremes: widest row (clamped) on a one-row frame; the
        // first drained pixels only come out if the row ends at the clamp.
        set_frame(11'd2047, 11'd0);
        run_frame(LINE_MAX, 1'b1, 1'b0);
        repeat (8) send_pixel(CMD_DRAIN, 8'($urandom));
        sent = LINE_MAX + 8;

        // Small random frames; a few are cut short and abandoned.
        while (sent < 1900) begin
            quiet = ($urandom_range(0, 5) == 0);
            w = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 12);
            h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 10);
            set_frame(11'(w), 11'(h));
            len = (w < 1 ? 1 : w) * (h < 1 ? 1 : h);
            if ($urandom_range(0, 7) == 0) begin
                len = $urandom_range(0, len);
                run_frame(len, $urandom_range(0, 1), 1'b0);
                repeat ($urandom_range(0, 3)) send_pixel(CMD_DRAIN, 8'($urandom));
            end
            else begin
                run_frame(len, $urandom_range(0, 3) != 0, 1'b1);
                // drains with nothing pending
                repeat ($urandom_range(0, 2)) send_pixel(CMD_DRAIN, 8'($urandom));
                len = len * 2;
            end
            sent += len;
        end
        in_valid <= 1'b0;
        quiet = 1'b0;

        wait (pending_pixels.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: hold stall for a drawn count, then release until taken
    // ------------------------------------------------------------------
    initial begin
        int hold;
        out_stall = 1'b1;
        wait (rst_n);
        forever begin
            hold = draw_gap();
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    // Compare every accepted pixel with the oldest expectation.
    always @(posedge clk) begin
        filtered_t exp_px;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel_out %0d end_of_frame %0b", pixel_out, end_of_frame);
                errors++;
            end
            else begin
                exp_px = pending_pixels.pop_front();
                if (pixel_out !== exp_px.pix) begin
                    $error("pixel_out expected %0d actual %0d", exp_px.pix, pixel_out);
                    errors++;
                end
                if (end_of_frame !== exp_px.eof) begin
                    $error("end_of_frame expected %0b actual %0b", exp_px.eof, end_of_frame);
                    errors++;
                end
            end
        end
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/bif_pkg.sv
hdl/bif_win.sv
hdl/bif_div.sv
hdl/bilateral_image_filter.sv
hdl/bif_checker.sv
sim/tb_bilateral_image_filter.sv
